FILE: rtl/core/glr16_pkg.sv
// Shared types, constants and helper functions for the ranged LFSR generator.
package glr16_pkg;

   localparam int DataWidth = 16;
   localparam int SpanWidth = DataWidth + 1;
   localparam int DivSteps  = DataWidth;
   localparam int CntWidth  = $clog2(DivSteps);

   localparam logic [DataWidth-1:0] DEFAULT_SEED = 16'hACE1;
   localparam logic [DataWidth-1:0] LFSR_TAPS    = 16'hB400;

   typedef logic [DataWidth-1:0] data_type;
   typedef logic [SpanWidth-1:0] span_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;   // latch bounds, advance the generator, clear the remainder
      logic step;    // one restoring-divide iteration
      logic finish;  // load the result registers
   } cmd_type;

   // Seed register value to generator state; zero selects the default seed
   function automatic data_type seed_to_state(input data_type seed);
      seed_to_state = (seed != '0) ? seed : DEFAULT_SEED;
   endfunction

   // One Galois shift: shift right, fold the taps in when the low bit was set
   function automatic data_type lfsr_advance(input data_type s);
      data_type nxt;
      nxt = s >> 1;
      if (s[0]) begin
         nxt = nxt ^ LFSR_TAPS;
      end
      lfsr_advance = nxt;
   endfunction

endpackage

FILE: rtl/core/glr16_ctrl.sv
// Controller: sequences accept, the divide iterations and the result transfer.
module glr16_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output glr16_pkg::cmd_type cmd
);
   import glr16_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [CntWidth-1:0] LastStep = CntWidth'(DivSteps - 1);

   logic [1:0]          state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   logic                slot_free;

   // Output slot is free when empty or being drained this cycle
   assign slot_free = !out_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   // Next-state and command logic
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on finish, cleared on transfer
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: rtl/core/glr16_dpath.sv
// Datapath: generator state, span, restoring remainder unit and result registers.
module glr16_dpath (
   input  logic                clock,
   input  logic                reset,
   input  glr16_pkg::cmd_type  cmd,
   input  logic                csr_we,
   input  glr16_pkg::data_type csr_wdata,
   input  glr16_pkg::data_type req_lower_bound,
   input  glr16_pkg::data_type req_upper_bound,
   output glr16_pkg::data_type rsp_ranged_value,
   output glr16_pkg::data_type rsp_raw_state,
   output logic                rsp_span_error
);
   import glr16_pkg::*;

   data_type gen_ff, gen_in;
   data_type lower_ff;
   span_type span_ff;
   span_type rem_ff;
   data_type dvd_ff;
   data_type ranged_ff;
   data_type raw_ff;
   logic     err_ff;

   logic [SpanWidth:0] trial;
   logic [SpanWidth:0] diff;
   logic               span_zero;
   data_type           reduced;

   // Generator state: seed load or one step per accepted request
   always_comb begin
      gen_in = gen_ff;
      if (csr_we) begin
         gen_in = seed_to_state(csr_wdata);
      end else if (cmd.start) begin
         gen_in = lfsr_advance(gen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= DEFAULT_SEED;
      end else begin
         gen_ff <= gen_in;
      end
   end

   // Restoring divide step: shift in one dividend bit, subtract when it fits
   assign trial     = {rem_ff, dvd_ff[DataWidth-1]};
   assign diff      = trial - {1'b0, span_ff};
   assign span_zero = (span_ff == '0);
   assign reduced   = span_zero ? gen_ff : rem_ff[DataWidth-1:0];

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lower_ff <= req_lower_bound;
         span_ff  <= {1'b0, req_upper_bound} - {1'b0, req_lower_bound} + SpanWidth'(1);
         rem_ff   <= '0;
         dvd_ff   <= lfsr_advance(gen_ff);
      end else if (cmd.step) begin
         if (trial >= {1'b0, span_ff}) begin
            rem_ff <= diff[SpanWidth-1:0];
         end else begin
            rem_ff <= trial[SpanWidth-1:0];
         end
         dvd_ff <= dvd_ff << 1;
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         ranged_ff <= reduced + lower_ff;
         raw_ff    <= gen_ff;
         err_ff    <= span_zero;
      end
   end

   assign rsp_ranged_value = ranged_ff;
   assign rsp_raw_state    = raw_ff;
   assign rsp_span_error   = err_ff;

endmodule

FILE: rtl/core/galois_lfsr16_ranged_random_core.sv
// Top level: 16-bit Galois LFSR (taps 0xB400) with ranged output via a remainder unit.
//
//   channel   ports                                       direction
//   request   req_valid/req_ready, lower/upper bound      in
//   response  rsp_valid/rsp_ready, ranged, raw, error     out
//   seed      csr_we, csr_wdata                           in, write only
//
// Each request passes from transfer to result as follows: the generator is stepped
// and the span formed, sixteen iterations of the restoring remainder unit run, and
// the result register is loaded. A new request is taken once the previous one has
// reached the result register; a stalled response holds only the finish step.
// Synchronous reset loads the generator with 0xACE1; a seed write reloads it at once.
module galois_lfsr16_ranged_random_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  glr16_pkg::data_type req_lower_bound,
   input  glr16_pkg::data_type req_upper_bound,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output glr16_pkg::data_type rsp_ranged_value,
   output glr16_pkg::data_type rsp_raw_state,
   output logic                rsp_span_error,
   input  logic                csr_we,
   input  glr16_pkg::data_type csr_wdata
);
   import glr16_pkg::*;

   cmd_type cmd;

   // Sequencer
   glr16_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Generator and remainder datapath
   glr16_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_raw_state    (rsp_raw_state),
      .rsp_span_error   (rsp_span_error)
   );

endmodule
